### rtl/lbc_pkg.sv
// Package: shared types, register indexes and size helper for the linear block codec.
package lbc_pkg;

  localparam int MAX_CODE_BITS    = 16;
  localparam int MAX_MESSAGE_BITS = 8;
  localparam int MAX_PARITY_BITS  = 8;
  localparam int ROW_STRIDE       = 8;

  // Configuration register indexes
  localparam logic [1:0] CFG_CODE_LENGTH    = 2'd0;
  localparam logic [1:0] CFG_MESSAGE_LENGTH = 2'd1;
  localparam logic [1:0] CFG_PARITY_MATRIX  = 2'd2;

  // Operation codes
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  localparam logic [4:0] CODE_LENGTH_RST    = 5'd7;
  localparam logic [3:0] MESSAGE_LENGTH_RST = 4'd4;
  localparam logic [63:0] PARITY_MATRIX_RST = 64'd84346371;

  typedef struct packed {
    logic        func;
    logic [7:0]  message_bits;
    logic [15:0] received_bits;
  } lbc_in_t;

  typedef struct packed {
    logic [15:0] codeword;
    logic [7:0]  syndrome;
    logic [4:0]  error_position;
    logic        uncorrectable;
    logic [15:0] corrected_word;
    logic [7:0]  message_out;
  } lbc_out_t;

  // Effective code sizes after saturation
  typedef struct packed {
    logic [4:0] n;
    logic [3:0] k;
    logic [3:0] r;
  } lbc_sizes_t;

  // One classified item between front and back
  typedef struct packed {
    logic        func;
    logic [3:0]  k;
    logic [3:0]  r;
    logic [15:0] word;   // codeword when encoding, masked received word when decoding
    logic [7:0]  check;  // syndrome when decoding
  } lbc_work_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic valid;
    logic full;
  } lbc_qstat_t;

  function automatic lbc_sizes_t lbc_sizes(input logic [4:0] code_length,
                                           input logic [3:0] message_length);
    logic [4:0] n;
    logic [4:0] k;
    lbc_sizes_t s;
    n = code_length;
    k = {1'b0, message_length};
    if (n < 5'd2) n = 5'd2;
    if (n > 5'(MAX_CODE_BITS)) n = 5'(MAX_CODE_BITS);
    if (k < 5'd1) k = 5'd1;
    if (k > 5'(MAX_MESSAGE_BITS)) k = 5'(MAX_MESSAGE_BITS);
    if (k > n - 5'd1) k = n - 5'd1;
    if (n - k > 5'(MAX_PARITY_BITS)) k = n - 5'(MAX_PARITY_BITS);
    s.n = n;
    s.k = k[3:0];
    s.r = 4'(n - k);
    return s;
  endfunction

endpackage

### rtl/lbc_front.sv
// Front end: register accepted items, mask inputs and form parity or syndrome bits.
module lbc_front import lbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  lbc_in_t     item,
  input  lbc_sizes_t  sizes,
  input  logic [63:0] parity_matrix,
  input  lbc_qstat_t  qstat,
  output logic        push,
  output lbc_work_t   entry
);

  logic    hold_valid;
  lbc_in_t hold_item;

  logic [15:0] v;
  logic [15:0] v_shift;
  logic [7:0]  m;
  logic [7:0]  data8;
  logic [7:0]  par;
  logic [7:0]  pcol;

  assign push = hold_valid && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
    if (accept) begin
      hold_item <= item;
    end
  end

  always_comb begin
    for (int b = 0; b < 16; b++) begin
      v[b] = hold_item.received_bits[b] && (5'(b) < sizes.n);
    end
    for (int j = 0; j < 8; j++) begin
      m[j] = hold_item.message_bits[j] && (4'(j) < sizes.k);
    end
    v_shift = v >> sizes.r;
    data8   = (hold_item.func == FUNC_DECODE) ? v_shift[7:0] : m;
    pcol    = '0;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        pcol[j] = parity_matrix[j * ROW_STRIDE + i];
      end
      par[i] = (4'(i) < sizes.r) &&
               ((^(data8 & pcol)) ^ ((hold_item.func == FUNC_DECODE) && v[i]));
    end
    entry.func  = hold_item.func;
    entry.k     = sizes.k;
    entry.r     = sizes.r;
    entry.check = par;
    if (hold_item.func == FUNC_DECODE) begin
      entry.word = v;
    end else begin
      entry.word = {8'b0, par} | ({8'b0, m} << sizes.r);
    end
  end

endmodule

### rtl/lbc_queue.sv
// Two-entry queue between front and back.
module lbc_queue import lbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lbc_work_t  wr_data,
  input  logic       pop,
  output lbc_qstat_t qstat,
  output lbc_work_t  rd_data
);

  lbc_work_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign qstat.valid = (count != 2'd0);
  assign qstat.full  = (count == 2'd2);
  assign rd_data     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && qstat.valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop && qstat.valid);
    end
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

### rtl/lbc_back.sv
// Back end: match the syndrome against columns of H, correct, register the result.
module lbc_back import lbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lbc_qstat_t  qstat,
  input  lbc_work_t   entry,
  input  logic [63:0] parity_matrix,
  output logic        pop,
  output logic        done,
  output lbc_out_t    result
);

  logic [7:0]  syn;
  logic [7:0]  rmask;
  logic [2:0]  bit_idx;
  logic        row_hit;
  logic [2:0]  row_idx;
  logic [4:0]  err_pos;
  logic        uncorr;
  logic [4:0]  flip_pos;
  logic [15:0] corrected;
  logic [15:0] corr_shift;
  lbc_out_t    res_next;

  // The result side never stalls: drain one entry a cycle
  assign pop = qstat.valid;

  always_comb begin
    syn = (entry.func == FUNC_DECODE) ? entry.check : 8'b0;
    for (int i = 0; i < 8; i++) begin
      rmask[i] = (4'(i) < entry.r);
    end
    bit_idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (syn[i]) bit_idx = 3'(i);
    end
    row_hit = 1'b0;
    row_idx = '0;
    for (int j = 7; j >= 0; j--) begin
      if ((4'(j) < entry.k) &&
          ((parity_matrix[j * ROW_STRIDE +: 8] & rmask) == syn)) begin
        row_hit = 1'b1;
        row_idx = 3'(j);
      end
    end
    err_pos = 5'd0;
    uncorr  = 1'b0;
    if (syn != 8'b0) begin
      if ($onehot(syn)) begin
        err_pos = {2'b0, bit_idx} + 5'd1;
      end else if (row_hit) begin
        err_pos = {1'b0, entry.r} + {2'b0, row_idx} + 5'd1;
      end else begin
        uncorr = 1'b1;
      end
    end
    flip_pos   = err_pos - 5'd1;
    corrected  = entry.word ^ ((err_pos != 5'd0) ? (16'd1 << flip_pos[3:0]) : 16'd0);
    corr_shift = corrected >> entry.r;

    res_next = '0;
    if (entry.func == FUNC_DECODE) begin
      res_next.syndrome       = syn;
      res_next.error_position = err_pos;
      res_next.uncorrectable  = uncorr;
      res_next.corrected_word = corrected;
      res_next.message_out    = corr_shift[7:0];
    end else begin
      res_next.codeword = entry.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= qstat.valid;
    end
    if (qstat.valid) begin
      result <= res_next;
    end
  end

endmodule

### rtl/linear_block_encode_syndrome_decode.sv
// Top level: systematic (n,k) linear block encoder and single-error syndrome decoder.
//
//   channel  signals                                  handshake
//   -------  ---------------------------------------  -------------------------------
//   item     start, busy, item (lbc_in_t)             beat when start && !busy
//   result   done, result (lbc_out_t)                 beat on every cycle done is high
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data beat when cfg_valid && cfg_ready
//
// One item per cycle sustained. Each beat on the item side passes the input
// register, then the two-entry queue, then the output register after the column
// match. The result side cannot stall, so the queue drains every cycle and busy is
// high only during reset. Synchronous reset restores the default (7,4) code and
// empties the pipeline.
module linear_block_encode_syndrome_decode import lbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        start,
  output logic        busy,
  input  lbc_in_t     item,
  // result channel
  output logic        done,
  output lbc_out_t    result,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [4:0]  code_length;
  logic [3:0]  message_length;
  logic [63:0] parity_matrix;

  lbc_sizes_t sizes;
  lbc_qstat_t qstat;
  lbc_work_t  push_entry;
  lbc_work_t  pop_entry;
  logic       accept;
  logic       push;
  logic       pop;

  // Hold off items in reset and whenever the queue cannot take the held item
  assign busy      = rst || qstat.full;
  assign accept    = start && !busy;
  assign cfg_ready = !rst;

  // Configuration registers; writes to unknown indexes drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      code_length    <= CODE_LENGTH_RST;
      message_length <= MESSAGE_LENGTH_RST;
      parity_matrix  <= PARITY_MATRIX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CODE_LENGTH:    code_length    <= cfg_data[4:0];
        CFG_MESSAGE_LENGTH: message_length <= cfg_data[3:0];
        CFG_PARITY_MATRIX:  parity_matrix  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate n and k to the supported ranges
  assign sizes = lbc_sizes(code_length, message_length);

  lbc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (item),
    .sizes        (sizes),
    .parity_matrix(parity_matrix),
    .qstat        (qstat),
    .push         (push),
    .entry        (push_entry)
  );

  lbc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(push_entry),
    .pop    (pop),
    .qstat  (qstat),
    .rd_data(pop_entry)
  );

  lbc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .entry        (pop_entry),
    .parity_matrix(parity_matrix),
    .pop          (pop),
    .done         (done),
    .result       (result)
  );

`ifndef NO_ASSERTIONS
  // Every accepted item yields its result through the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted item produced no result on time");

  // No result without a matching accepted item
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result without a matching accepted item");

  // An uncorrectable word has a nonzero syndrome and no flipped position
  a_uncorr: assert property (@(posedge clk) disable iff (rst)
    (done && result.uncorrectable) |->
      (result.syndrome != 8'd0 && result.error_position == 5'd0))
    else $error("uncorrectable flag inconsistent with syndrome");

  // A reported correction has a nonzero syndrome and is not marked uncorrectable
  a_one_flip: assert property (@(posedge clk) disable iff (rst)
    (done && result.error_position != 5'd0) |->
      (!result.uncorrectable && result.syndrome != 8'd0))
    else $error("correction reported with zero syndrome");
`endif

endmodule
